// ===== rtl/core/cpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared constants for the circular pattern matcher.
// ----------------------------------------------------------------------------
package cpm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CHAR_W      = 8;
    localparam int OUT_W       = 8;

    // tuser codes on the input side
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // result tdata bit positions
    localparam int FOUND_BIT    = 0;
    localparam int OVERFLOW_BIT = 1;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [CHAR_W-1:0] char_t;

endpackage
`default_nettype wire

// ===== rtl/core/circular_pattern_matcher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_pattern_matcher_unit
// Reports whether any cyclic rotation of a loaded pattern appears in a text.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata            | tuser             | tlast
//  --------+-----+------------------+-------------------+---------------------
//  s_axis  | in  | [7:0] character  | [0] operation     | last pattern/text
//  m_axis  | out | [0] found,       | -                 | -
//          |     | [1] overflow     |                   |
//
//  One item per cycle. Each item is finished in the cycle it is taken; a
//  result (text item with tlast) is in m_axis_tdata in the next cycle.
//  The rate is set by one lane update per pattern position: each lane keeps
//  the length of the text run that matches the periodic pattern ending at
//  that position, and all lanes advance together on every text item.
//  Reset (aresetn low, synchronous) clears control state and lane counters.
//  s_axis_tready drops only while a result waits and m_axis_tready is low.
//
module circular_pattern_matcher_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [cpm_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] character
    input  wire                          s_axis_tuser,   // [0] operation
    input  wire                          s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [cpm_pkg::OUT_W-1:0]    m_axis_tdata    // [0] found, [1] overflow
);

    localparam int PM = cpm_pkg::PATTERN_MAX;
    localparam int LW = cpm_pkg::LEN_W;

    cpm_pkg::char_t pat_reg [PM];
    logic [LW-1:0]  cnt_reg [PM];
    logic [LW-1:0]  cnt_next [PM];
    logic [LW-1:0]  prev_cnt [PM];

    cpm_pkg::len_t  len_reg, len_next, len_base;
    logic           ovf_reg, ovf_next, ovf_base;
    logic           loading_reg, loading_next;
    logic           in_text_reg, in_text_next;
    logic           match_reg, match_next;
    logic           out_valid_reg, out_valid_next;
    logic           found_reg, found_next;
    logic           oflow_reg, oflow_next;

    logic           accept;
    logic           is_text;
    logic           pat_write;
    logic [LW-1:0]  wrap_cnt;
    logic           any_hit;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_text       = (s_axis_tuser == cpm_pkg::OP_TEXT);

    // pattern loading
    always_comb begin
        len_base  = loading_reg ? len_reg : '0;
        ovf_base  = loading_reg ? ovf_reg : 1'b0;
        pat_write = 1'b0;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        loading_next = loading_reg;
        if (accept) begin
            if (!is_text) begin
                if (len_base < LW'(PM)) begin
                    pat_write = 1'b1;
                    len_next  = len_base + 1'b1;
                    ovf_next  = ovf_base;
                end else begin
                    len_next  = len_base;
                    ovf_next  = 1'b1;
                end
                loading_next = !s_axis_tlast;
            end else begin
                loading_next = 1'b0;
            end
        end
    end

    // lane update: lane r holds the run length of text matching the
    // periodic pattern ending at position r; lane 0 continues from lane len-1
    always_comb begin
        wrap_cnt = '0;
        for (int r = 0; r < PM; r++) begin
            if (LW'(r + 1) == len_reg) begin
                wrap_cnt = wrap_cnt | cnt_reg[r];
            end
        end
        prev_cnt[0] = in_text_reg ? wrap_cnt : '0;
        for (int r = 1; r < PM; r++) begin
            prev_cnt[r] = in_text_reg ? cnt_reg[r-1] : '0;
        end
        any_hit = 1'b0;
        for (int r = 0; r < PM; r++) begin
            if ((LW'(r) < len_reg) && (s_axis_tdata == pat_reg[r])) begin
                cnt_next[r] = (prev_cnt[r] == len_reg) ? len_reg : prev_cnt[r] + 1'b1;
            end else begin
                cnt_next[r] = '0;
            end
            if ((LW'(r) < len_reg) && (cnt_next[r] == len_reg)) begin
                any_hit = 1'b1;
            end
        end
    end

    // text tracking and result
    always_comb begin
        in_text_next   = in_text_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        found_next     = found_reg;
        oflow_next     = oflow_reg;
        if (accept) begin
            if (!is_text) begin
                in_text_next = 1'b0;
            end else begin
                match_next   = (in_text_reg && match_reg) || (any_hit && !ovf_reg);
                in_text_next = !s_axis_tlast;
                if (s_axis_tlast) begin
                    out_valid_next = 1'b1;
                    found_next     = match_next && !ovf_reg;
                    oflow_next     = ovf_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            loading_reg   <= 1'b0;
            in_text_reg   <= 1'b0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < PM; r++) begin
                cnt_reg[r] <= '0;
            end
        end else begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            loading_reg   <= loading_next;
            in_text_reg   <= in_text_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
            if (accept && is_text) begin
                for (int r = 0; r < PM; r++) begin
                    cnt_reg[r] <= cnt_next[r];
                end
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        oflow_reg <= oflow_next;
    end

    // pattern store, written at the running length
    always_ff @(posedge aclk) begin
        if (pat_write) begin
            pat_reg[len_base[cpm_pkg::IDX_W-1:0]] <= s_axis_tdata;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[cpm_pkg::FOUND_BIT]    = found_reg;
        m_axis_tdata[cpm_pkg::OVERFLOW_BIT] = oflow_reg;
    end
    assign m_axis_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/cpm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpm_checker
// Port-level checks for circular_pattern_matcher_unit.
// ----------------------------------------------------------------------------
module cpm_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        s_axis_tvalid,
    input wire                        s_axis_tready,
    input wire [cpm_pkg::CHAR_W-1:0]  s_axis_tdata,
    input wire                        s_axis_tuser,
    input wire                        s_axis_tlast,
    input wire                        m_axis_tvalid,
    input wire                        m_axis_tready,
    input wire [cpm_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an overflowed pattern never reports a match
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[cpm_pkg::OVERFLOW_BIT]
            |-> !m_axis_tdata[cpm_pkg::FOUND_BIT])
        else $error("found with overflow");

    // a new result follows only a final text item
    a_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid)
            |-> $past(s_acc && (s_axis_tuser == cpm_pkg::OP_TEXT) && s_axis_tlast))
        else $error("result without final text item");

    // pattern items produce no result
    a_pat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_axis_tuser == cpm_pkg::OP_PATTERN) && (!m_axis_tvalid || m_axis_tready)
            |=> !m_axis_tvalid)
        else $error("result after pattern item");

endmodule

bind circular_pattern_matcher_unit cpm_checker u_cpm_checker (.*);
`default_nettype wire
